// ===== rtl/core/tcu_pkg.sv =====
// Shared types, constants and helpers for the two-channel countdown timer.
package tcu_pkg;

    localparam int DEF_WINDOW_BYTES  = 128;
    localparam int DEF_CHANNEL_BYTES = 64;

    // channel 0 sits at 0x40 and up, channel 1 below
    localparam logic [7:0] CH0_BASE = 8'h40;

    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_RD_BYTE = 3'd1,
        ACT_RD_WORD = 3'd2,
        ACT_WR_BYTE = 3'd3,
        ACT_WR_WORD = 3'd4
    } action_t;

    typedef logic [6:0] widx_t;

    // word index of each register inside a channel
    localparam widx_t W_MCR   = 7'd0;
    localparam widx_t W_IR    = 7'd2;
    localparam widx_t W_CR    = 7'd3;
    localparam widx_t W_SR    = 7'd4;
    localparam widx_t W_CNTR  = 7'd5;
    localparam widx_t W_PREL1 = 7'd6;
    localparam widx_t W_PREL2 = 7'd7;
    localparam widx_t W_COM   = 7'd8;

    // control register bits
    localparam int CR_SWR  = 15;
    localparam int CR_TGE  = 11;
    localparam int CR_PCLK = 10;
    localparam int CR_CPE  = 9;
    localparam int CR_CLK  = 8;

    // status register bits
    localparam int SR_IRQ = 15;
    localparam int SR_TO  = 14;
    localparam int SR_TC  = 12;
    localparam int SR_ON  = 10;
    localparam int SR_COM = 8;

    localparam logic [15:0] SR_FLAGS   = 16'h7000;
    localparam logic [15:0] ON_MASK    = 16'h8200;
    localparam logic [15:0] SR_LOW_SET = 16'h00FF;

    localparam logic [2:0] MODE_FIXED = 3'd1;
    localparam logic [2:0] MODE_VAR   = 3'd2;

    localparam logic [9:0] PRE_BASE = 10'd2;

    typedef struct packed {
        logic [15:0] mcr;
        logic [15:0] ir;
        logic [15:0] cr;
        logic [15:0] sr;
        logic [15:0] cntr;
        logic [15:0] prel1;
        logic [15:0] prel2;
        logic [15:0] com;
        logic [8:0]  div;
        logic        phase;
    } chan_t;

    localparam chan_t CHAN_RST = '{
        mcr:   16'h0000,
        ir:    16'h000F,
        cr:    16'h0000,
        sr:    16'h00FF,
        cntr:  16'h0000,
        prel1: 16'hFFFF,
        prel2: 16'hFFFF,
        com:   16'h0000,
        div:   9'd0,
        phase: 1'b1
    };

    // prescaler period for PCLK source: twice the power-of-two select; select zero gives the largest period
    function automatic logic [9:0] prescale_div(input logic [2:0] sel);
        logic [9:0] p;
        case (sel)
            3'd0:    p = 10'd512;
            default: p = PRE_BASE << sel;
        endcase
        return p;
    endfunction

    // ON follows SWR|CPE, IRQ follows enabled flags
    function automatic logic [15:0] sr_norm(input logic [15:0] sr, input logic [15:0] cr);
        logic [15:0] n;
        n         = sr;
        n[SR_ON]  = |(cr & ON_MASK);
        n[SR_IRQ] = |(sr & cr & SR_FLAGS);
        return n;
    endfunction

endpackage

// ===== rtl/core/two_channel_countdown_timer_unit.sv =====
// Two-channel countdown timer: register window, prescalers and counters.
//
// Usage:
//   Input requests arrive on s_tvalid/s_tready with s_tuser carrying the
//   action (tick, byte/word read, byte/word write) and s_tdata the address
//   and write data. Every request, ticks included, yields exactly one
//   result request on m_tvalid/m_tready: read data plus both channels'
//   IRQ bit, interrupt level and vector as they stand after the request.
//   Throughput is one request per cycle unless the result stalls; the
//   input register takes the request and the result register follows it
//   to m_tvalid. The scratch memory read is issued at acceptance with a
//   write bypass from the request ahead of it.
//   Reset puts every register at its reset value and clears the scratch
//   valid bits, so no clearing pass is needed; requests are taken from the
//   first cycle after reset.
//   When m_tready is low the result register holds; the input register
//   still takes one request, after which s_tready drops until the result
//   is taken.
module two_channel_countdown_timer_unit
    import tcu_pkg::*;
#(
    parameter int WINDOW_BYTES  = DEF_WINDOW_BYTES,
    parameter int CHANNEL_BYTES = DEF_CHANNEL_BYTES
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[7:0], write_data[23:8]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // read_data[15:0], irq_chan0[16], irq_chan1[17],
                                   // level_chan0[20:18], level_chan1[23:21],
                                   // vector_chan0[31:24], vector_chan1[39:32]
);

    localparam int NWORDS    = CHANNEL_BYTES / 2;
    localparam int MEM_DEPTH = 2 * NWORDS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [7:0]        NWORDS_L  = 8'(NWORDS);
    localparam logic [8:0]        WINDOW_L  = 9'(WINDOW_BYTES);
    localparam logic [MEM_AW-1:0] CH1_WBASE = MEM_AW'(NWORDS);

    typedef struct packed {
        logic              ok;
        logic              ch;
        widx_t             widx;
        logic              lane;
        logic [MEM_AW-1:0] midx;
    } dec_t;

    function automatic dec_t decode(input logic [7:0] a);
        dec_t       d;
        logic [7:0] loc;
        d.ch   = (a < CH0_BASE);
        loc    = d.ch ? a : a - CH0_BASE;
        d.widx = loc[7:1];
        d.lane = loc[0];
        d.ok   = ({1'b0, a} < WINDOW_L) && ({1'b0, d.widx} < NWORDS_L);
        d.midx = d.ch ? CH1_WBASE + d.widx[MEM_AW-1:0] : d.widx[MEM_AW-1:0];
        return d;
    endfunction

    function automatic logic is_named(input widx_t w);
        logic r;
        unique case (w) inside
            W_MCR, W_IR, W_CR, W_SR, W_CNTR, W_PREL1, W_PREL2, W_COM: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] word_of(input chan_t c, input widx_t w,
                                            input logic [15:0] scr);
        logic [15:0] r;
        unique case (w)
            W_MCR:   r = c.mcr;
            W_IR:    r = c.ir;
            W_CR:    r = c.cr;
            W_SR:    r = c.sr;
            W_CNTR:  r = c.cntr;
            W_PREL1: r = c.prel1;
            W_PREL2: r = c.prel2;
            W_COM:   r = c.com;
            default: r = scr;
        endcase
        return r;
    endfunction

    function automatic chan_t chan_write(input chan_t c, input widx_t w,
                                         input logic [15:0] v, input logic [15:0] clr);
        chan_t n;
        n = c;
        unique case (w)
            W_MCR:   n.mcr = v;
            W_IR:    n.ir  = v;
            W_CR:
            begin
                n.cr = v;
                if (c.cr[CR_SWR] && !v[CR_SWR])
                begin
                    n.sr         = c.sr | SR_LOW_SET;
                    n.sr[SR_COM] = 1'b0;
                    n.cntr       = 16'h0000;
                    n.phase      = 1'b1;
                end
                else if (!c.cr[CR_SWR] && v[CR_SWR])
                begin
                    n.cntr  = c.prel1;
                    n.phase = 1'b1;
                end
                n.div = 9'd0;
            end
            W_SR:    n.sr    = c.sr & ~(clr & SR_FLAGS);
            W_CNTR:  n.cntr  = v;
            W_PREL1: n.prel1 = v;
            W_PREL2: n.prel2 = v;
            W_COM:
            begin
                n.com        = v;
                n.sr[SR_COM] = 1'b0;
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic chan_t chan_tick(input chan_t c);
        chan_t       n;
        logic [2:0]  mode;
        logic        run;
        logic [9:0]  pre;
        logic [9:0]  t;
        logic [9:0]  trem;
        logic [15:0] cnt;
        logic [15:0] diff;
        logic        ph;
        n    = c;
        mode = c.cr[4:2];
        run  = c.cr[CR_SWR] && (mode == MODE_FIXED || mode == MODE_VAR)
               && c.cr[CR_CPE] && !c.cr[CR_TGE] && !c.cr[CR_CLK];
        pre  = c.cr[CR_PCLK] ? prescale_div(c.cr[7:5]) : PRE_BASE;
        cnt  = (c.cntr == 16'h0000) ? c.prel1 : c.cntr;
        ph   = (c.cntr == 16'h0000) ? 1'b1 : c.phase;
        t    = {1'b0, c.div} + 10'd1;
        trem = t - pre;
        diff = cnt - c.com;
        if (run)
        begin
            n.cntr  = cnt;
            n.phase = ph;
            if (t < pre)
            begin
                n.div = t[8:0];
            end
            else
            begin
                n.div = trem[8:0];
                if (cnt == 16'h0001)
                begin
                    if (c.com == 16'h0000)
                    begin
                        n.sr[SR_TC] = 1'b1;
                    end
                    n.sr[SR_TO]  = 1'b1;
                    n.sr[SR_COM] = 1'b0;
                    if (mode == MODE_VAR)
                    begin
                        n.cntr  = ph ? c.prel2 : c.prel1;
                        n.phase = !ph;
                    end
                    else
                    begin
                        n.cntr = c.prel1;
                    end
                end
                else
                begin
                    if (diff == 16'h0001)
                    begin
                        n.sr[SR_COM] = 1'b1;
                        n.sr[SR_TC]  = 1'b1;
                    end
                    n.cntr = cnt - 16'h0001;
                end
            end
        end
        return n;
    endfunction

    // handshake
    logic        s1_valid_reg;
    action_t     s1_act_reg;
    logic [7:0]  s1_addr_reg;
    logic [15:0] s1_wdata_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic        adv;
    logic        accept;

    // register state
    chan_t chan_reg  [2];
    chan_t chan_next [2];

    // scratch bytes
    logic [15:0] scratch_mem [MEM_DEPTH];
    logic [1:0]  vld_reg     [MEM_DEPTH];
    logic [15:0] rd_word_reg;
    logic [1:0]  rd_vld_reg;
    logic [1:0]  byp_be_reg;
    logic [15:0] byp_data_reg;

    dec_t        d0;
    dec_t        d1;
    logic        is_wr;
    logic        is_wr_b;
    logic        mem_we;
    logic [1:0]  mem_be;
    logic [15:0] mem_wd;
    logic [1:0]  byp_be;
    logic [15:0] scratch;
    logic [15:0] old_word;
    logic [15:0] wr_val;
    logic [15:0] clr_mask;
    logic [15:0] rdata;

    assign adv      = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign d0 = decode(s_tdata[7:0]);
    assign d1 = decode(s1_addr_reg);

    assign is_wr_b = (s1_act_reg == ACT_WR_BYTE);
    assign is_wr   = is_wr_b || (s1_act_reg == ACT_WR_WORD);

    assign scratch[15:8] = byp_be_reg[1] ? byp_data_reg[15:8]
                         : (rd_vld_reg[1] ? rd_word_reg[15:8] : 8'h00);
    assign scratch[7:0]  = byp_be_reg[0] ? byp_data_reg[7:0]
                         : (rd_vld_reg[0] ? rd_word_reg[7:0] : 8'h00);

    assign old_word = word_of(chan_reg[d1.ch], d1.widx, scratch);

    always_comb
    begin
        if (!is_wr_b)
        begin
            wr_val   = s1_wdata_reg;
            clr_mask = s1_wdata_reg;
            mem_be   = 2'b11;
            mem_wd   = s1_wdata_reg;
        end
        else if (d1.lane)
        begin
            wr_val   = {old_word[15:8], s1_wdata_reg[7:0]};
            clr_mask = 16'h0000;
            mem_be   = 2'b01;
            mem_wd   = {s1_wdata_reg[7:0], s1_wdata_reg[7:0]};
        end
        else
        begin
            wr_val   = {s1_wdata_reg[7:0], old_word[7:0]};
            clr_mask = {s1_wdata_reg[7:0], 8'h00};
            mem_be   = 2'b10;
            mem_wd   = {s1_wdata_reg[7:0], s1_wdata_reg[7:0]};
        end
    end

    assign mem_we = adv && d1.ok && is_wr && !is_named(d1.widx);
    assign byp_be = (mem_we && d0.midx == d1.midx) ? mem_be : 2'b00;

    always_comb
    begin
        rdata = 16'h0000;
        if (d1.ok)
        begin
            if (s1_act_reg == ACT_RD_WORD)
            begin
                rdata = old_word;
            end
            else if (s1_act_reg == ACT_RD_BYTE)
            begin
                rdata = d1.lane ? {8'h00, old_word[7:0]} : {8'h00, old_word[15:8]};
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            chan_next[i] = chan_reg[i];
            if (s1_act_reg == ACT_TICK)
            begin
                chan_next[i] = chan_tick(chan_reg[i]);
            end
            else if (is_wr && d1.ok && d1.ch == 1'(i))
            begin
                chan_next[i] = chan_write(chan_reg[i], d1.widx, wr_val, clr_mask);
            end
            chan_next[i].sr = sr_norm(chan_next[i].sr, chan_next[i].cr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chan_reg[0]   <= CHAN_RST;
            chan_reg[1]   <= CHAN_RST;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                chan_reg[0]   <= chan_next[0];
                chan_reg[1]   <= chan_next[1];
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg   <= action_t'(s_tuser);
            s1_addr_reg  <= s_tdata[7:0];
            s1_wdata_reg <= s_tdata[23:8];
        end
        if (adv)
        begin
            out_data_reg <= {chan_next[1].ir[7:0], chan_next[0].ir[7:0],
                             chan_next[1].ir[10:8], chan_next[0].ir[10:8],
                             chan_next[1].sr[SR_IRQ], chan_next[0].sr[SR_IRQ], rdata};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (mem_be[1])
            begin
                scratch_mem[d1.midx][15:8] <= mem_wd[15:8];
            end
            if (mem_be[0])
            begin
                scratch_mem[d1.midx][7:0] <= mem_wd[7:0];
            end
        end
        if (accept)
        begin
            rd_word_reg  <= scratch_mem[d0.midx];
            byp_data_reg <= mem_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_DEPTH; i++)
            begin
                vld_reg[i] <= 2'b00;
            end
            rd_vld_reg <= 2'b00;
            byp_be_reg <= 2'b00;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[d1.midx] <= vld_reg[d1.midx] | mem_be;
            end
            if (accept)
            begin
                rd_vld_reg <= vld_reg[d0.midx];
                byp_be_reg <= byp_be;
            end
        end
    end

endmodule

// ===== rtl/core/tcu_checker.sv =====
// Port-level checks for the two-channel countdown timer, bound to the top level.
module tcu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input not ready without output stall");

    // an accepted request reaches the output once the receiver is ready
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind two_channel_countdown_timer_unit tcu_checker u_tcu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_two_channel_countdown_timer_unit.sv =====
// Self-checking testbench for the two-channel countdown timer: directed, pressure and random traffic.
`timescale 1ns / 1ps

module tb_two_channel_countdown_timer_unit;
    import tcu_pkg::*;

    typedef struct packed {
        logic [15:0] rdata;
        logic        irq0;
        logic        irq1;
        logic [2:0]  lvl0;
        logic [2:0]  lvl1;
        logic [7:0]  vec0;
        logic [7:0]  vec1;
    } readback_t;

    localparam int CHB = DEF_CHANNEL_BYTES;

    localparam logic [7:0] OFF_MCR   = {W_MCR, 1'b0};
    localparam logic [7:0] OFF_IR    = {W_IR, 1'b0};
    localparam logic [7:0] OFF_CR    = {W_CR, 1'b0};
    localparam logic [7:0] OFF_SR    = {W_SR, 1'b0};
    localparam logic [7:0] OFF_CNTR  = {W_CNTR, 1'b0};
    localparam logic [7:0] OFF_PREL1 = {W_PREL1, 1'b0};
    localparam logic [7:0] OFF_PREL2 = {W_PREL2, 1'b0};
    localparam logic [7:0] OFF_COM   = {W_COM, 1'b0};
    localparam logic [7:0] CH1_BASE  = 8'h00;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // address[7:0], write_data[23:8]
    logic [2:0]  s_tuser = '0;     // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // read_data[15:0], irq_chan0[16], irq_chan1[17],
                                   // level_chan0[20:18], level_chan1[23:21],
                                   // vector_chan0[31:24], vector_chan1[39:32]

    // predicted register file, channel 0 in the lower half
    logic [7:0] timer_image [0:2*CHB-1];
    logic [8:0] prescale_phase [0:1];
    logic       take_prel2 [0:1];

    readback_t   due_readbacks [$];
    int unsigned counted_items = 0;
    int unsigned result_count = 0;
    int unsigned error_count = 0;
    bit          src_idle = 1'b0;
    bit          sink_idle = 1'b0;
    int          hold_len = 0;

    two_channel_countdown_timer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] word_at(int ch, int off);
        if (off + 1 >= CHB)
            return 16'h0000;
        return {timer_image[ch*CHB+off], timer_image[ch*CHB+off+1]};
    endfunction

    function automatic void put_word(int ch, int off, logic [15:0] v);
        if (off + 1 >= CHB)
            return;
        timer_image[ch*CHB+off]   = v[15:8];
        timer_image[ch*CHB+off+1] = v[7:0];
    endfunction

    function automatic void refresh_status(int ch);
        logic [15:0] ctl;
        logic [15:0] st;
        ctl = word_at(ch, OFF_CR);
        st = word_at(ch, OFF_SR);
        st[SR_ON]  = ctl[CR_SWR] | ctl[CR_CPE];
        st[SR_IRQ] = |(st & ctl & SR_FLAGS);
        put_word(ch, OFF_SR, st);
    endfunction

    function automatic void tick_one(int ch);
        logic [15:0] ctl;
        logic [15:0] cnt;
        logic [15:0] cmp;
        logic [15:0] st;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [2:0]  mode;
        int          pre;
        int          t;
        ctl = word_at(ch, OFF_CR);
        mode = ctl[4:2];
        if (!ctl[CR_SWR] || ctl[CR_CLK])
            return;
        if (mode != MODE_FIXED && mode != MODE_VAR)
            return;
        if (ctl[CR_TGE] || !ctl[CR_CPE])
            return;
        if (!ctl[CR_PCLK])
            pre = 2;
        else
            pre = (ctl[7:5] == 3'd0) ? 512 : (2 << ctl[7:5]);

        cnt = word_at(ch, OFF_CNTR);
        if (cnt == 16'h0000)
        begin
            cnt = word_at(ch, OFF_PREL1);
            take_prel2[ch] = 1'b1;
        end
        t = int'(prescale_phase[ch]) + 1;
        if (t < pre)
        begin
            prescale_phase[ch] = 9'(t);
            put_word(ch, OFF_CNTR, cnt);
            return;
        end
        prescale_phase[ch] = 9'(t - pre);

        p1 = word_at(ch, OFF_PREL1);
        p2 = word_at(ch, OFF_PREL2);
        cmp = word_at(ch, OFF_COM);
        st = word_at(ch, OFF_SR);
        if (cnt == 16'd1)
        begin
            // end of period
            if (cmp == 16'h0000)
                st[SR_TC] = 1'b1;
            st[SR_TO]  = 1'b1;
            st[SR_COM] = 1'b0;
            if (mode == MODE_VAR)
            begin
                cnt = take_prel2[ch] ? p2 : p1;
                take_prel2[ch] = ~take_prel2[ch];
            end
            else
                cnt = p1;
        end
        else
        begin
            if (16'(cnt - cmp) == 16'd1)
            begin
                st[SR_COM] = 1'b1;
                st[SR_TC]  = 1'b1;
            end
            cnt = cnt - 16'd1;
        end
        put_word(ch, OFF_SR, st);
        refresh_status(ch);
        put_word(ch, OFF_CNTR, cnt);
    endfunction

    function automatic void apply_write(int ch, int loc_off, logic [15:0] value, bit is_byte);
        int          off;
        logic [15:0] old;
        logic [15:0] v;
        logic [15:0] clr;
        logic [15:0] st;
        off = loc_off & ~1;
        old = word_at(ch, off);
        v = value;
        if (is_byte)
            v = (loc_off & 1) ? {old[15:8], value[7:0]} : {value[7:0], old[7:0]};
        if (off == OFF_SR)
        begin
            // write-one-to-clear; odd byte clears nothing
            clr = is_byte ? (((loc_off & 1) == 0) ? (v & 16'hFF00) : 16'h0000) : v;
            put_word(ch, OFF_SR, old & ~(clr & SR_FLAGS));
            refresh_status(ch);
            return;
        end
        put_word(ch, off, v);
        if (off == OFF_CR)
        begin
            if (old[CR_SWR] && !v[CR_SWR])
            begin
                st = word_at(ch, OFF_SR);
                st[7:0]    = 8'hFF;
                st[SR_COM] = 1'b0;
                put_word(ch, OFF_SR, st);
                put_word(ch, OFF_CNTR, 16'h0000);
                take_prel2[ch] = 1'b1;
            end
            else if (!old[CR_SWR] && v[CR_SWR])
            begin
                put_word(ch, OFF_CNTR, word_at(ch, OFF_PREL1));
                take_prel2[ch] = 1'b1;
            end
            prescale_phase[ch] = 9'd0;
            refresh_status(ch);
        end
        else if (off == OFF_COM)
        begin
            st = word_at(ch, OFF_SR);
            st[SR_COM] = 1'b0;
            put_word(ch, OFF_SR, st);
            refresh_status(ch);
        end
        else if (off inside {OFF_MCR, OFF_IR, OFF_CNTR, OFF_PREL1, OFF_PREL2})
            refresh_status(ch);
    endfunction

    function automatic readback_t timer_predict(logic [2:0] act, logic [7:0] addr,
                                                logic [15:0] wdata);
        readback_t   r;
        int          ch;
        int          loc_off;
        logic [15:0] sr0;
        logic [15:0] sr1;
        logic [15:0] ir0;
        logic [15:0] ir1;
        r = '0;
        if (act == ACT_TICK)
        begin
            tick_one(0);
            tick_one(1);
        end
        else if (act <= ACT_WR_WORD && addr < DEF_WINDOW_BYTES)
        begin
            ch = (addr >= CH0_BASE) ? 0 : 1;
            loc_off = (ch == 0) ? int'(addr) - int'(CH0_BASE) : int'(addr);
            if (loc_off < CHB)
            begin
                case (act)
                    ACT_RD_BYTE: r.rdata = {8'h00, timer_image[ch*CHB+loc_off]};
                    ACT_RD_WORD: r.rdata = word_at(ch, loc_off & ~1);
                    ACT_WR_BYTE: apply_write(ch, loc_off, wdata, 1'b1);
                    default:     apply_write(ch, loc_off, wdata, 1'b0);
                endcase
            end
        end
        sr0 = word_at(0, OFF_SR);
        sr1 = word_at(1, OFF_SR);
        ir0 = word_at(0, OFF_IR);
        ir1 = word_at(1, OFF_IR);
        r.irq0 = sr0[SR_IRQ];
        r.irq1 = sr1[SR_IRQ];
        r.lvl0 = ir0[10:8];
        r.lvl1 = ir1[10:8];
        r.vec0 = ir0[7:0];
        r.vec1 = ir1[7:0];
        return r;
    endfunction

    // mostly short, now and then long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [15:0] small_value();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 6));
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        $display("result %0d: %s got %h want %h", result_count, what, got, want);
    endtask

    task automatic send_req(input logic [2:0] act, input logic [7:0] addr,
                            input logic [15:0] wdata);
        int span;
        span = (src_idle && $urandom_range(0, 3) == 0) ? idle_span() : 0;
        if (span > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (span) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {wdata, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        due_readbacks.push_back(timer_predict(act, addr, wdata));
        counted_items++;
    endtask

    always @(posedge clk)
    begin
        readback_t got;
        readback_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rdata = m_tdata[15:0];
            got.irq0  = m_tdata[16];
            got.irq1  = m_tdata[17];
            got.lvl0  = m_tdata[20:18];
            got.lvl1  = m_tdata[23:21];
            got.vec0  = m_tdata[31:24];
            got.vec1  = m_tdata[39:32];
            if (due_readbacks.size() == 0)
                report_mismatch("unexpected request", got.rdata, 16'h0000);
            else
            begin
                want = due_readbacks.pop_front();
                if (got.rdata !== want.rdata)
                    report_mismatch("read_data", got.rdata, want.rdata);
                if (got.irq0 !== want.irq0)
                    report_mismatch("irq_chan0", 16'(got.irq0), 16'(want.irq0));
                if (got.irq1 !== want.irq1)
                    report_mismatch("irq_chan1", 16'(got.irq1), 16'(want.irq1));
                if (got.lvl0 !== want.lvl0)
                    report_mismatch("level_chan0", 16'(got.lvl0), 16'(want.lvl0));
                if (got.lvl1 !== want.lvl1)
                    report_mismatch("level_chan1", 16'(got.lvl1), 16'(want.lvl1));
                if (got.vec0 !== want.vec0)
                    report_mismatch("vector_chan0", 16'(got.vec0), 16'(want.vec0));
                if (got.vec1 !== want.vec1)
                    report_mismatch("vector_chan1", 16'(got.vec1), 16'(want.vec1));
            end
            result_count++;
        end
    end

    // result sink: random stalls, plus long hold-offs on demand
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_len != 0)
            begin
                n = hold_len;
                hold_len = 0;
            end
            else if (sink_idle && $urandom_range(0, 7) == 0)
                n = idle_span();
            else
                n = 0;
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic test_reset_values();
        send_req(ACT_RD_WORD, CH0_BASE + OFF_IR, 16'h0000);
        send_req(ACT_RD_WORD, CH1_BASE + OFF_SR, 16'hFFFF);
        send_req(ACT_RD_WORD, CH0_BASE + OFF_PREL1, 16'h0000);
        send_req(ACT_RD_BYTE, CH0_BASE + OFF_IR + 8'd1, 16'h0000);
        send_req(ACT_RD_WORD, CH1_BASE + OFF_PREL2, 16'h0000);
    endtask

    task automatic test_window_edges();
        send_req(ACT_RD_WORD, 8'h80, 16'h0000);
        send_req(ACT_RD_BYTE, 8'hFF, 16'h0000);
        send_req(ACT_WR_WORD, 8'hC6, 16'hFFFF);
        send_req(ACT_WR_BYTE, 8'h7E, 16'h00A5);
        send_req(ACT_RD_WORD, 8'h7F, 16'h0000);     // odd word aligns down
        send_req(ACT_RD_BYTE, 8'h3F, 16'h0000);
        send_req(3'd5, CH0_BASE + OFF_CR, 16'hFFFF);
        send_req(3'd6, CH0_BASE + OFF_CR, 16'hFFFF);
        send_req(3'd7, CH0_BASE + OFF_CR, 16'hFFFF);
    endtask

    task automatic test_timer_run();
        send_req(ACT_WR_WORD, CH1_BASE + OFF_PREL1, 16'h0002);
        send_req(ACT_WR_WORD, CH1_BASE + OFF_COM, 16'h0001);
        send_req(ACT_WR_WORD, CH1_BASE + OFF_IR, 16'hFFFF);
        // run, fixed duty, TO and TC enabled
        send_req(ACT_WR_WORD, CH1_BASE + OFF_CR, 16'hD204);
        repeat (5) send_req(ACT_TICK, 8'h00, 16'h0000);
        send_req(ACT_RD_WORD, CH1_BASE + OFF_SR, 16'h0000);
        send_req(ACT_WR_BYTE, CH1_BASE + OFF_SR + 8'd1, 16'h00FF);
        send_req(ACT_WR_BYTE, CH1_BASE + OFF_SR, 16'h0010);
        send_req(ACT_WR_WORD, CH1_BASE + OFF_SR, 16'hFFFF);
        send_req(ACT_WR_WORD, CH1_BASE + OFF_CR, 16'h0000);
        send_req(ACT_RD_WORD, CH1_BASE + OFF_CNTR, 16'h0000);
    endtask

    task automatic test_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        hold_len  = 150;
        repeat (40)
            send_req($urandom_range(0, 1) ? ACT_TICK : ACT_RD_WORD,
                     8'($urandom_range(0, 127)), 16'($urandom));
    endtask

    task automatic test_random_traffic();
        logic [7:0]  base;
        logic [15:0] ctl;
        int unsigned target;
        int          r;
        target = counted_items + 1500;
        while (counted_items < target)
        begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 9) < 4)
            begin
                repeat ($urandom_range(4, 20))
                    send_req(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom));
            end
            else
            begin
                base = $urandom_range(0, 1) ? CH0_BASE : CH1_BASE;
                if ($urandom_range(0, 3) == 0)
                    send_req(ACT_WR_WORD, base + OFF_CR, 16'h0000);
                send_req(ACT_WR_WORD, base + OFF_PREL1, small_value());
                send_req(ACT_WR_WORD, base + OFF_PREL2, small_value());
                send_req(ACT_WR_WORD, base + OFF_COM, small_value());
                if ($urandom_range(0, 2) == 0)
                    send_req(ACT_WR_WORD, base + OFF_IR, 16'($urandom));
                ctl = 16'($urandom) & 16'h7003;
                ctl[CR_SWR]  = $urandom_range(0, 7) != 0;
                ctl[CR_CPE]  = $urandom_range(0, 7) != 0;
                ctl[CR_TGE]  = $urandom_range(0, 15) == 0;
                ctl[CR_CLK]  = $urandom_range(0, 15) == 0;
                ctl[CR_PCLK] = $urandom_range(0, 5) == 0;
                ctl[7:5] = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'd1;
                if ($urandom_range(0, 7) == 0)
                    ctl[4:2] = 3'($urandom);
                else
                    ctl[4:2] = $urandom_range(0, 1) ? MODE_FIXED : MODE_VAR;
                send_req(ACT_WR_WORD, base + OFF_CR, ctl);
                repeat ($urandom_range(8, 40))
                begin
                    r = $urandom_range(0, 19);
                    if (r < 12)
                        send_req(ACT_TICK, 8'($urandom), 16'($urandom));
                    else if (r < 15)
                        send_req($urandom_range(0, 1) ? ACT_RD_WORD : ACT_RD_BYTE,
                                 base + 8'($urandom_range(0, 19)), 16'h0000);
                    else if (r < 17)
                        send_req($urandom_range(0, 1) ? ACT_WR_WORD : ACT_WR_BYTE,
                                 base + OFF_SR + 8'($urandom_range(0, 1)), 16'($urandom));
                    else if (r == 17)
                        send_req(ACT_WR_WORD, base + ($urandom_range(0, 1) ? OFF_CNTR : OFF_COM),
                                 small_value());
                    else if (r == 18)
                        send_req(ACT_RD_BYTE, base + 8'($urandom_range(0, 63)), 16'h0000);
                    else
                        send_req(ACT_WR_BYTE, base + OFF_CR + 8'd1, 16'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 2*CHB; i++)
            timer_image[i] = 8'h00;
        for (int c = 0; c < 2; c++)
        begin
            put_word(c, OFF_IR, 16'h000F);
            put_word(c, OFF_SR, 16'h00FF);
            put_word(c, OFF_PREL1, 16'hFFFF);
            put_word(c, OFF_PREL2, 16'hFFFF);
            prescale_phase[c] = 9'd0;
            take_prel2[c] = 1'b1;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_window_edges();
        test_timer_run();
        test_backpressure();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (due_readbacks.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
